@@ src/kdt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_pkg: shared types, constants and control store for keyed_deque_table
// Opcodes, sequencer step names, control word layout and ring index helpers.
// ----------------------------------------------------------------------------
package kdt_pkg;

    localparam int CAPACITY  = 16;
    localparam int DATA_BITS = 32;
    localparam int KEY_BITS  = 32;
    localparam int OP_BITS   = 3;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_LOOKUP     = 3'd3,
        OP_DELETE     = 3'd4
    } opcode_t;

    // sequencer steps = control store addresses
    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_PUSH_BACK,
        STEP_PUSH_FRONT,
        STEP_POP,
        STEP_SCAN,
        STEP_FRONT_RD,
        STEP_EMIT
    } step_t;

    // datapath action of a step
    typedef enum logic [2:0] {
        ACT_LATCH,
        ACT_PUSH_BACK,
        ACT_PUSH_FRONT,
        ACT_POP,
        ACT_SCAN,
        ACT_FRONT_RD,
        ACT_EMIT
    } act_t;

    // jump condition
    typedef enum logic [1:0] {
        JC_NEXT,      // unconditional to target
        JC_DISPATCH,  // on accept, jump by opcode; else hold
        JC_SCAN,      // hold while scan has work, then target
        JC_OUT_FREE   // hold until output register free, then target
    } jc_t;

    typedef struct packed {
        act_t  act;
        jc_t   jc;
        step_t target;
    } ctl_t;

    // control store
    function automatic ctl_t ucode(input step_t s);
        ctl_t c;
        unique case (s)
            STEP_IDLE:       c = '{act: ACT_LATCH,      jc: JC_DISPATCH, target: STEP_IDLE};
            STEP_PUSH_BACK:  c = '{act: ACT_PUSH_BACK,  jc: JC_NEXT,     target: STEP_FRONT_RD};
            STEP_PUSH_FRONT: c = '{act: ACT_PUSH_FRONT, jc: JC_NEXT,     target: STEP_FRONT_RD};
            STEP_POP:        c = '{act: ACT_POP,        jc: JC_NEXT,     target: STEP_FRONT_RD};
            STEP_SCAN:       c = '{act: ACT_SCAN,       jc: JC_SCAN,     target: STEP_FRONT_RD};
            STEP_FRONT_RD:   c = '{act: ACT_FRONT_RD,   jc: JC_NEXT,     target: STEP_EMIT};
            STEP_EMIT:       c = '{act: ACT_EMIT,       jc: JC_OUT_FREE, target: STEP_IDLE};
            default:         c = '{act: ACT_LATCH,      jc: JC_NEXT,     target: STEP_IDLE};
        endcase
        return c;
    endfunction

    // ring position base + off, with base < CAPACITY and off <= CAPACITY
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(CAPACITY)) begin
            s = s - (CNT_W+1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(CAPACITY - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] p);
        return (p == '0) ? IDX_W'(CAPACITY - 1) : p - IDX_W'(1);
    endfunction

endpackage

@@ src/keyed_deque_table.sv @@
`timescale 1ns / 1ps
// Push back, push front and pop run their datapath step, then the front read and the
// emit step; undefined opcodes skip the datapath step. Lookup and delete scan the
// records held with one key compare per cycle over a 1R1W record RAM, then read the
// front and emit; a lookup ends early at its first match.
// Items are handled one at a time; s_ready is high only while the sequencer is idle.
// Reset (aresetn low, synchronous) empties the store; record RAM contents are kept.
// ----------------------------------------------------------------------------
// keyed_deque_table: keyed double-ended queue
// Ring buffer of records (key, payload) in a 1R1W RAM, run by a small
// microcoded sequencer. Lookup scans front to back; delete compacts the
// survivors in place, in order, reading ahead of the write pointer.
// ----------------------------------------------------------------------------
module keyed_deque_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kdt_pkg::OP_BITS-1:0]   s_opcode,
    input  logic [kdt_pkg::KEY_BITS-1:0]  s_key,
    input  logic [kdt_pkg::DATA_BITS-1:0] s_payload,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_status,
    output logic                          m_is_empty,
    output logic [kdt_pkg::KEY_BITS-1:0]  m_front_key,
    output logic [kdt_pkg::DATA_BITS-1:0] m_front_data,
    output logic                          m_hit,
    output logic [kdt_pkg::KEY_BITS-1:0]  m_match_key,
    output logic [kdt_pkg::DATA_BITS-1:0] m_match_data
);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    kdt_pkg::step_t step_reg, step_next;
    kdt_pkg::ctl_t  ctl;

    // ring state: head position and record count
    logic [kdt_pkg::IDX_W-1:0] head_reg, head_next;
    logic [kdt_pkg::CNT_W-1:0] count_reg, count_next;

    // scan state: read index, compacted write index, read data pending
    logic [kdt_pkg::CNT_W-1:0] scan_reg, scan_next;
    logic [kdt_pkg::CNT_W-1:0] wr_reg, wr_next;
    logic                      rdv_reg, rdv_next;

    // item being worked on
    logic [kdt_pkg::OP_BITS-1:0]   op_reg, op_next;
    logic [kdt_pkg::KEY_BITS-1:0]  key_reg, key_next;
    logic [kdt_pkg::DATA_BITS-1:0] pay_reg, pay_next;
    logic                          status_reg, status_next;
    logic                          hit_reg, hit_next;
    logic [kdt_pkg::KEY_BITS-1:0]  mkey_reg, mkey_next;
    logic [kdt_pkg::DATA_BITS-1:0] mdata_reg, mdata_next;

    // result register
    logic                          m_valid_reg, m_valid_next;
    logic                          m_status_reg, m_status_next;
    logic                          m_is_empty_reg, m_is_empty_next;
    logic [kdt_pkg::KEY_BITS-1:0]  m_front_key_reg, m_front_key_next;
    logic [kdt_pkg::DATA_BITS-1:0] m_front_data_reg, m_front_data_next;
    logic                          m_hit_reg, m_hit_next;
    logic [kdt_pkg::KEY_BITS-1:0]  m_match_key_reg, m_match_key_next;
    logic [kdt_pkg::DATA_BITS-1:0] m_match_data_reg, m_match_data_next;

    // record RAM
    logic [kdt_pkg::KEY_BITS-1:0]  key_mem  [kdt_pkg::CAPACITY];
    logic [kdt_pkg::DATA_BITS-1:0] data_mem [kdt_pkg::CAPACITY];
    logic                          mem_wr_en;
    logic [kdt_pkg::IDX_W-1:0]     mem_wr_addr;
    logic [kdt_pkg::KEY_BITS-1:0]  mem_wr_key;
    logic [kdt_pkg::DATA_BITS-1:0] mem_wr_data;
    logic                          mem_rd_en;
    logic [kdt_pkg::IDX_W-1:0]     mem_rd_addr;
    logic [kdt_pkg::KEY_BITS-1:0]  rd_key_reg;
    logic [kdt_pkg::DATA_BITS-1:0] rd_data_reg;

    logic accept;
    logic out_free;
    logic is_lookup;
    logic is_delete;
    logic issue;      // scan reads another record this cycle
    logic match;      // record read last cycle matches the key
    logic found;      // lookup hit: scan stops
    logic scan_busy;

    assign ctl       = kdt_pkg::ucode(step_reg);
    assign s_ready   = (step_reg == kdt_pkg::STEP_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign is_lookup = (op_reg == kdt_pkg::OP_LOOKUP);
    assign is_delete = (op_reg == kdt_pkg::OP_DELETE);
    assign issue     = (scan_reg < count_reg);
    assign match     = rdv_reg && (rd_key_reg == key_reg);
    assign found     = is_lookup && match;
    assign scan_busy = issue && !found;

    // next step: jump logic
    always_comb begin
        step_next = step_reg;
        unique case (ctl.jc)
            kdt_pkg::JC_NEXT: begin
                step_next = ctl.target;
            end
            kdt_pkg::JC_DISPATCH: begin
                if (accept) begin
                    unique case (s_opcode)
                        kdt_pkg::OP_PUSH_BACK:  step_next = kdt_pkg::STEP_PUSH_BACK;
                        kdt_pkg::OP_PUSH_FRONT: step_next = kdt_pkg::STEP_PUSH_FRONT;
                        kdt_pkg::OP_POP_FRONT:  step_next = kdt_pkg::STEP_POP;
                        kdt_pkg::OP_LOOKUP,
                        kdt_pkg::OP_DELETE:     step_next = kdt_pkg::STEP_SCAN;
                        default:                step_next = kdt_pkg::STEP_FRONT_RD;
                    endcase
                end
            end
            kdt_pkg::JC_SCAN: begin
                step_next = scan_busy ? step_reg : ctl.target;
            end
            kdt_pkg::JC_OUT_FREE: begin
                step_next = out_free ? ctl.target : step_reg;
            end
            default: begin
                step_next = kdt_pkg::STEP_IDLE;
            end
        endcase
    end

    // datapath controls decoded from the control word
    always_comb begin
        head_next         = head_reg;
        count_next        = count_reg;
        scan_next         = scan_reg;
        wr_next           = wr_reg;
        rdv_next          = rdv_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        pay_next          = pay_reg;
        status_next       = status_reg;
        hit_next          = hit_reg;
        mkey_next         = mkey_reg;
        mdata_next        = mdata_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_status_next     = m_status_reg;
        m_is_empty_next   = m_is_empty_reg;
        m_front_key_next  = m_front_key_reg;
        m_front_data_next = m_front_data_reg;
        m_hit_next        = m_hit_reg;
        m_match_key_next  = m_match_key_reg;
        m_match_data_next = m_match_data_reg;
        mem_wr_en         = 1'b0;
        mem_wr_addr       = kdt_pkg::wrap_add(head_reg, count_reg);
        mem_wr_key        = key_reg;
        mem_wr_data       = pay_reg;
        mem_rd_en         = 1'b0;
        mem_rd_addr       = head_reg;

        unique case (ctl.act)
            kdt_pkg::ACT_LATCH: begin
                if (accept) begin
                    op_next     = s_opcode;
                    key_next    = s_key;
                    pay_next    = s_payload;
                    status_next = 1'b0;
                    hit_next    = 1'b0;
                    mkey_next   = '0;
                    mdata_next  = '0;
                    scan_next   = '0;
                    wr_next     = '0;
                    rdv_next    = 1'b0;
                end
            end
            kdt_pkg::ACT_PUSH_BACK: begin
                if (count_reg == kdt_pkg::CNT_W'(kdt_pkg::CAPACITY)) begin
                    status_next = 1'b1;
                end else begin
                    mem_wr_en  = 1'b1;
                    count_next = count_reg + kdt_pkg::CNT_W'(1);
                end
            end
            kdt_pkg::ACT_PUSH_FRONT: begin
                if (count_reg == kdt_pkg::CNT_W'(kdt_pkg::CAPACITY)) begin
                    status_next = 1'b1;
                end else begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = kdt_pkg::wrap_dec(head_reg);
                    head_next   = kdt_pkg::wrap_dec(head_reg);
                    count_next  = count_reg + kdt_pkg::CNT_W'(1);
                end
            end
            kdt_pkg::ACT_POP: begin
                if (count_reg != '0) begin
                    head_next  = kdt_pkg::wrap_inc(head_reg);
                    count_next = count_reg - kdt_pkg::CNT_W'(1);
                end
            end
            kdt_pkg::ACT_SCAN: begin
                // read ahead one record while the previous one is compared
                mem_rd_en   = issue;
                mem_rd_addr = kdt_pkg::wrap_add(head_reg, scan_reg);
                rdv_next    = issue;
                if (issue) begin
                    scan_next = scan_reg + kdt_pkg::CNT_W'(1);
                end
                if (match) begin
                    hit_next = 1'b1;
                    if (is_lookup) begin
                        mkey_next  = rd_key_reg;
                        mdata_next = rd_data_reg;
                    end
                end else if (rdv_reg && is_delete) begin
                    // survivor moves down to the compacted position
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = kdt_pkg::wrap_add(head_reg, wr_reg);
                    mem_wr_key  = rd_key_reg;
                    mem_wr_data = rd_data_reg;
                    wr_next     = wr_reg + kdt_pkg::CNT_W'(1);
                end
                if (!scan_busy && is_delete) begin
                    count_next = wr_next;
                end
            end
            kdt_pkg::ACT_FRONT_RD: begin
                mem_rd_en = 1'b1;
            end
            kdt_pkg::ACT_EMIT: begin
                // keep the front read alive while the output is stalled
                mem_rd_en = 1'b1;
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = status_reg;
                    m_is_empty_next   = (count_reg == '0);
                    m_front_key_next  = (count_reg == '0) ? '0 : rd_key_reg;
                    m_front_data_next = (count_reg == '0) ? '0 : rd_data_reg;
                    m_hit_next        = hit_reg;
                    m_match_key_next  = mkey_reg;
                    m_match_data_next = mdata_reg;
                end
            end
            default: begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= kdt_pkg::STEP_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            scan_reg    <= '0;
            wr_reg      <= '0;
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            wr_reg      <= wr_next;
            rdv_reg     <= rdv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg           <= op_next;
        key_reg          <= key_next;
        pay_reg          <= pay_next;
        status_reg       <= status_next;
        hit_reg          <= hit_next;
        mkey_reg         <= mkey_next;
        mdata_reg        <= mdata_next;
        m_status_reg     <= m_status_next;
        m_is_empty_reg   <= m_is_empty_next;
        m_front_key_reg  <= m_front_key_next;
        m_front_data_reg <= m_front_data_next;
        m_hit_reg        <= m_hit_next;
        m_match_key_reg  <= m_match_key_next;
        m_match_data_reg <= m_match_data_next;
    end

    // record RAM: one write, one registered read
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            key_mem[mem_wr_addr]  <= mem_wr_key;
            data_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_key_reg  <= key_mem[mem_rd_addr];
            rd_data_reg <= data_mem[mem_rd_addr];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_is_empty   = m_is_empty_reg;
    assign m_front_key  = m_front_key_reg;
    assign m_front_data = m_front_data_reg;
    assign m_hit        = m_hit_reg;
    assign m_match_key  = m_match_key_reg;
    assign m_match_data = m_match_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= kdt_pkg::CNT_W'(kdt_pkg::CAPACITY))
        else $error("record count above capacity");

    a_compact_behind_read: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_reg <= scan_reg)
        else $error("compaction write index passed read index");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(step_reg == kdt_pkg::STEP_EMIT))
        else $error("result raised outside emit step");

    a_empty_front_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_is_empty_reg) |-> (m_front_key_reg == '0 && m_front_data_reg == '0))
        else $error("empty store reports a front record");

    a_miss_match_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_hit_reg) |-> (m_match_key_reg == '0 && m_match_data_reg == '0))
        else $error("match fields set without a hit");

endmodule

@@ test/kdt_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdt_result_checker: result prediction and comparison for keyed_deque_table
// Keeps its own copy of the record store, updates it on every accepted
// request and checks each accepted result item against the oldest prediction.
// ----------------------------------------------------------------------------
module kdt_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [kdt_pkg::OP_BITS-1:0]   s_opcode,
    input  logic [kdt_pkg::KEY_BITS-1:0]  s_key,
    input  logic [kdt_pkg::DATA_BITS-1:0] s_payload,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_status,
    input  logic                          m_is_empty,
    input  logic [kdt_pkg::KEY_BITS-1:0]  m_front_key,
    input  logic [kdt_pkg::DATA_BITS-1:0] m_front_data,
    input  logic                          m_hit,
    input  logic [kdt_pkg::KEY_BITS-1:0]  m_match_key,
    input  logic [kdt_pkg::DATA_BITS-1:0] m_match_data,
    output int                            fail_count,
    output int                            open_results
);

    typedef struct {
        logic                          status;
        logic                          is_empty;
        logic [kdt_pkg::KEY_BITS-1:0]  front_key;
        logic [kdt_pkg::DATA_BITS-1:0] front_data;
        logic                          hit;
        logic [kdt_pkg::KEY_BITS-1:0]  match_key;
        logic [kdt_pkg::DATA_BITS-1:0] match_data;
    } table_result_t;

    // mirrored store, position 0 is the front
    logic [kdt_pkg::KEY_BITS-1:0]  rec_key  [kdt_pkg::CAPACITY];
    logic [kdt_pkg::DATA_BITS-1:0] rec_data [kdt_pkg::CAPACITY];
    int                            rec_count = 0;

    table_result_t                 due_results [$];
    int                            fails = 0;

    initial begin
        fail_count   = 0;
        open_results = 0;
    end

    function automatic table_result_t apply_request(
        input logic [kdt_pkg::OP_BITS-1:0]   op,
        input logic [kdt_pkg::KEY_BITS-1:0]  key,
        input logic [kdt_pkg::DATA_BITS-1:0] data);
        table_result_t r;
        int            kept;
        r = '{default: '0};
        case (op)
            kdt_pkg::OP_PUSH_BACK: begin
                if (rec_count >= kdt_pkg::CAPACITY) begin
                    r.status = 1'b1;
                end else begin
                    rec_key[rec_count]  = key;
                    rec_data[rec_count] = data;
                    rec_count++;
                end
            end
            kdt_pkg::OP_PUSH_FRONT: begin
                if (rec_count >= kdt_pkg::CAPACITY) begin
                    r.status = 1'b1;
                end else begin
                    for (int i = rec_count; i > 0; i--) begin
                        rec_key[i]  = rec_key[i-1];
                        rec_data[i] = rec_data[i-1];
                    end
                    rec_key[0]  = key;
                    rec_data[0] = data;
                    rec_count++;
                end
            end
            kdt_pkg::OP_POP_FRONT: begin
                if (rec_count > 0) begin
                    for (int i = 1; i < rec_count; i++) begin
                        rec_key[i-1]  = rec_key[i];
                        rec_data[i-1] = rec_data[i];
                    end
                    rec_count--;
                end
            end
            kdt_pkg::OP_LOOKUP: begin
                for (int i = 0; i < rec_count; i++) begin
                    if (!r.hit && rec_key[i] == key) begin
                        r.hit        = 1'b1;
                        r.match_key  = rec_key[i];
                        r.match_data = rec_data[i];
                    end
                end
            end
            kdt_pkg::OP_DELETE: begin
                kept = 0;
                for (int i = 0; i < rec_count; i++) begin
                    if (rec_key[i] == key) begin
                        r.hit = 1'b1;
                    end else begin
                        rec_key[kept]  = rec_key[i];
                        rec_data[kept] = rec_data[i];
                        kept++;
                    end
                end
                rec_count = kept;
            end
            default: ;  // no operation
        endcase
        r.is_empty = (rec_count == 0);
        if (rec_count > 0) begin
            r.front_key  = rec_key[0];
            r.front_data = rec_data[0];
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        table_result_t want;
        if (!aresetn) begin
            rec_count = 0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result item with no request outstanding", $time);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    compare_field("status",     64'(want.status),     64'(m_status));
                    compare_field("is_empty",   64'(want.is_empty),   64'(m_is_empty));
                    compare_field("front_key",  64'(want.front_key),  64'(m_front_key));
                    compare_field("front_data", 64'(want.front_data), 64'(m_front_data));
                    compare_field("hit",        64'(want.hit),        64'(m_hit));
                    compare_field("match_key",  64'(want.match_key),  64'(m_match_key));
                    compare_field("match_data", 64'(want.match_data), 64'(m_match_data));
                end
            end
            if (s_valid && s_ready) begin
                due_results.push_back(apply_request(s_opcode, s_key, s_payload));
            end
        end
        fail_count   <= fails;
        open_results <= due_results.size();
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for keyed_deque_table
// Drives directed and random requests with random gaps, stalls the result
// side at random, and reports the checker's verdict at the end of the run.
// ----------------------------------------------------------------------------
module testbench;

    // no accept on either channel for this long means the block is stuck;
    // the long receiver hold-off plus a full scan stays well below it
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int HOLDOFF_START  = 3000;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int SEGMENT_ITEMS  = 40;
    localparam int KEY_POOL       = 8;
    localparam int TAIL_CYCLES    = 30;

    // opcodes the block treats as no operation
    localparam logic [kdt_pkg::OP_BITS-1:0] OP_NONE_FIRST = 3'd5;
    localparam logic [kdt_pkg::OP_BITS-1:0] OP_NONE_LAST  = 3'd7;

    typedef enum { RX_OPEN, RX_JITTER, RX_SHUT } rx_mode_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [kdt_pkg::OP_BITS-1:0]   s_opcode;
    logic [kdt_pkg::KEY_BITS-1:0]  s_key;
    logic [kdt_pkg::DATA_BITS-1:0] s_payload;
    logic                          m_valid;
    logic                          m_ready;
    logic                          m_status;
    logic                          m_is_empty;
    logic [kdt_pkg::KEY_BITS-1:0]  m_front_key;
    logic [kdt_pkg::DATA_BITS-1:0] m_front_data;
    logic                          m_hit;
    logic [kdt_pkg::KEY_BITS-1:0]  m_match_key;
    logic [kdt_pkg::DATA_BITS-1:0] m_match_data;

    int                            fail_count;
    int                            open_results;
    int                            idle_cycles = 0;

    // small key set so that lookups and deletes hit often
    logic [kdt_pkg::KEY_BITS-1:0]  key_pool [KEY_POOL];

    always #1 aclk = ~aclk;

    keyed_deque_table i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_key        (s_key),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_is_empty   (m_is_empty),
        .m_front_key  (m_front_key),
        .m_front_data (m_front_data),
        .m_hit        (m_hit),
        .m_match_key  (m_match_key),
        .m_match_data (m_match_data)
    );

    kdt_result_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_key        (s_key),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_is_empty   (m_is_empty),
        .m_front_key  (m_front_key),
        .m_front_data (m_front_data),
        .m_hit        (m_hit),
        .m_match_key  (m_match_key),
        .m_match_data (m_match_data),
        .fail_count   (fail_count),
        .open_results (open_results)
    );

    // watchdog: count cycles with no accept on either side
    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offer one request. Optional gap first; valid stays up until accepted.
    // Called and returns at a falling edge.
    task automatic send_item(input logic [kdt_pkg::OP_BITS-1:0]   op,
                             input logic [kdt_pkg::KEY_BITS-1:0]  key,
                             input logic [kdt_pkg::DATA_BITS-1:0] data);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_key     <= key;
        s_payload <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [kdt_pkg::KEY_BITS-1:0] pick_key();
        if ($urandom_range(0, 99) < 85) begin
            return key_pool[$urandom_range(0, KEY_POOL - 1)];
        end
        return $urandom;
    endfunction

    // Opcode mix is picked at random per segment, filling or draining, so the
    // record count sweeps between empty and full.
    function automatic logic [kdt_pkg::OP_BITS-1:0] pick_op(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 35) return kdt_pkg::OP_PUSH_BACK;
            if (r < 60) return kdt_pkg::OP_PUSH_FRONT;
            if (r < 70) return kdt_pkg::OP_POP_FRONT;
            if (r < 85) return kdt_pkg::OP_LOOKUP;
            if (r < 95) return kdt_pkg::OP_DELETE;
        end else begin
            if (r < 15) return kdt_pkg::OP_PUSH_BACK;
            if (r < 25) return kdt_pkg::OP_PUSH_FRONT;
            if (r < 60) return kdt_pkg::OP_POP_FRONT;
            if (r < 75) return kdt_pkg::OP_LOOKUP;
            if (r < 95) return kdt_pkg::OP_DELETE;
        end
        return kdt_pkg::OP_BITS'($urandom_range(OP_NONE_FIRST, OP_NONE_LAST));
    endfunction

    // Result side: open bursts, jittery ready, shut stretches (mostly short), and once
    // a long hold-off while the sender keeps offering so the input stalls.
    initial begin
        rx_mode_t mode;
        int       r;
        int       span;
        int       cyc;
        bit       held_off;
        m_ready  = 1'b0;
        cyc      = 0;
        held_off = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (!held_off && cyc >= HOLDOFF_START) begin
                held_off = 1'b1;
                mode     = RX_SHUT;
                span     = HOLDOFF_CYCLES;
            end else if (r < 45) begin
                mode = RX_OPEN;
                span = $urandom_range(1, 40);
            end else if (r < 90) begin
                mode = RX_JITTER;
                span = $urandom_range(1, 30);
            end else begin
                mode = RX_SHUT;
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 5);
            end
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    RX_OPEN:   m_ready <= 1'b1;
                    RX_JITTER: m_ready <= ($urandom_range(0, 99) < 65);
                    default:   m_ready <= 1'b0;
                endcase
                cyc++;
            end
        end
    end

    // Request side
    initial begin
        bit filling;
        s_valid   = 1'b0;
        s_opcode  = kdt_pkg::OP_PUSH_BACK;
        s_key     = '0;
        s_payload = '0;
        aresetn   = 1'b0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) begin
            key_pool[i] = $urandom;
        end

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed part ---
        // empty store: pop does nothing, lookup and delete miss
        send_item(kdt_pkg::OP_POP_FRONT, '0, '0);
        send_item(kdt_pkg::OP_LOOKUP,    '0, '0);
        send_item(kdt_pkg::OP_DELETE,    '1, '0);
        // field extremes
        send_item(kdt_pkg::OP_PUSH_BACK,  '0, '0);
        send_item(kdt_pkg::OP_PUSH_BACK,  '1, '1);
        send_item(kdt_pkg::OP_PUSH_FRONT, 32'h1, 32'hAAAA_5555);
        send_item(kdt_pkg::OP_LOOKUP,     '1, '0);              // hit at the back
        send_item(kdt_pkg::OP_LOOKUP,     32'h0012_3456, '0);   // miss on a non-empty store
        // unused opcodes leave the store alone
        for (int op = OP_NONE_FIRST; op <= OP_NONE_LAST; op++) begin
            send_item(op[kdt_pkg::OP_BITS-1:0], $urandom, $urandom);
        end
        // fill to capacity, every other record with the same key
        for (int i = 3; i < kdt_pkg::CAPACITY; i++) begin
            send_item((i % 2) ? kdt_pkg::OP_PUSH_FRONT : kdt_pkg::OP_PUSH_BACK,
                      (i % 2) ? 32'h7 : kdt_pkg::KEY_BITS'(i + 100), $urandom);
        end
        // push on a full store is dropped with status set
        send_item(kdt_pkg::OP_PUSH_BACK,  32'h55, 32'h66);
        send_item(kdt_pkg::OP_PUSH_FRONT, 32'h55, 32'h66);
        // delete of a key held several times keeps the rest in order
        send_item(kdt_pkg::OP_DELETE, 32'h7, '0);
        send_item(kdt_pkg::OP_LOOKUP, 32'h7, '0);

        // --- random part ---
        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % SEGMENT_ITEMS == 0) begin
                filling = ($urandom_range(0, 1) == 1);
            end
            send_item(pick_op(filling), pick_key(), $urandom);
        end
        s_valid <= 1'b0;

        // drain, then let the block settle before the verdict
        while (open_results != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
